// ===== hdl/crbc_pkg.sv =====
// Shared types and constants of the color rectangle bounding-box checker.
`default_nettype none

package crbc_pkg;

  // Largest screen dimension; positions and box corners are 12 bits wide.
  localparam int MAX_DIM = 4096;
  localparam int POS_W   = 12;
  localparam int DIM_W   = 13;
  localparam int CNT_W   = 25;
  localparam int HASH_W  = 32;
  localparam int RGB_W   = 24;
  localparam int AREA_W  = 2 * DIM_W;

  localparam logic [DIM_W-1:0]  DIM_MAX    = DIM_W'(MAX_DIM);
  localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(MAX_DIM - 1);
  localparam logic [HASH_W-1:0] FNV_BASIS  = 32'h811C_9DC5;
  localparam logic [HASH_W-1:0] FNV_PRIME  = 32'h0100_0193;
  localparam logic [CNT_W-1:0]  COUNT_MAX  = {CNT_W{1'b1}};

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_RGB  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_MODE     = 3'd7;

  localparam logic [DIM_W-1:0] RST_SCREEN_WIDTH  = 13'd1024;
  localparam logic [DIM_W-1:0] RST_SCREEN_HEIGHT = 13'd768;
  localparam logic [DIM_W-1:0] RST_RECT_WIDTH    = 13'd256;
  localparam logic [DIM_W-1:0] RST_RECT_HEIGHT   = 13'd256;

  // Verdict codes.
  localparam int VERDICT_W = 3;
  localparam logic [VERDICT_W-1:0] VERDICT_PASS         = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_NO_MATCH     = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_WRONG_ORIGIN = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_WRONG_SIZE   = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_NOT_FILLED   = 3'd4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic [HASH_W-1:0]    checksum;
    logic [CNT_W-1:0]     matched_count;
    logic [POS_W-1:0]     box_left;
    logic [POS_W-1:0]     box_top;
    logic [POS_W-1:0]     box_right;
    logic [POS_W-1:0]     box_bottom;
    logic [DIM_W-1:0]     expect_width;
    logic [DIM_W-1:0]     expect_height;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // pixel taken: fold red, update count, box and position
    logic fold_g;
    logic fold_b;
    logic extent;   // register the expected box size
    logic area;     // register expected width times height
    logic finish;   // load the result register and clear the frame
  } cmd_t;

  typedef struct packed {
    logic frame_end;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/crbc_ctrl.sv =====
// Sequencer of the checker: per-pixel hash steps and the end-of-frame evaluation.
`default_nettype none

module crbc_ctrl
  import crbc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FOLD_G,
    S_FOLD_B,
    S_EXTENT,
    S_AREA,
    S_REPORT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_FOLD_G;
        end
      end
      S_FOLD_G: begin
        cmd_o.fold_g = 1'b1;
        state_d      = S_FOLD_B;
      end
      S_FOLD_B: begin
        cmd_o.fold_b = 1'b1;
        state_d      = status_i.frame_end ? S_EXTENT : S_IDLE;
      end
      S_EXTENT: begin
        cmd_o.extent = 1'b1;
        state_d      = S_AREA;
      end
      S_AREA: begin
        cmd_o.area = 1'b1;
        state_d    = S_REPORT;
      end
      S_REPORT: begin
        // The result waits here until the output register is free.
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/crbc_datapath.sv =====
// Datapath of the checker: configuration, hash, match count, bounding box and verdict.
`default_nettype none

module crbc_datapath
  import crbc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire pixel_t                in_data_i,
  input  wire cmd_t                  cmd_i,
  output status_t                    status_o,
  output result_t                    out_data_o
);

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clip_extent(input logic [POS_W-1:0] org,
                                                   input logic [DIM_W-1:0] len,
                                                   input logic [DIM_W-1:0] scr);
    logic [DIM_W:0]   sum;
    logic [DIM_W-1:0] r;
    sum = {2'b00, org} + {1'b0, len};
    if ({1'b0, org} >= scr) begin
      r = '0;
    end else if (sum > {1'b0, scr}) begin
      r = scr - {1'b0, org};
    end else begin
      r = len;
    end
    return r;
  endfunction

  // Configuration registers.
  logic [RGB_W-1:0] expected_rgb_q;
  logic [DIM_W-1:0] screen_width_q, screen_height_q, rect_width_q, rect_height_q;
  logic [POS_W-1:0] origin_x_q, origin_y_q;
  logic             clip_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_rgb_q  <= '0;
      screen_width_q  <= RST_SCREEN_WIDTH;
      screen_height_q <= RST_SCREEN_HEIGHT;
      rect_width_q    <= RST_RECT_WIDTH;
      rect_height_q   <= RST_RECT_HEIGHT;
      origin_x_q      <= '0;
      origin_y_q      <= '0;
      clip_mode_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_EXPECTED_RGB:  expected_rgb_q  <= cfg_data_i[RGB_W-1:0];
        REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i[DIM_W-1:0];
        REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i[DIM_W-1:0];
        REG_RECT_WIDTH:    rect_width_q    <= cfg_data_i[DIM_W-1:0];
        REG_RECT_HEIGHT:   rect_height_q   <= cfg_data_i[DIM_W-1:0];
        REG_ORIGIN_X:      origin_x_q      <= cfg_data_i[POS_W-1:0];
        REG_ORIGIN_Y:      origin_y_q      <= cfg_data_i[POS_W-1:0];
        REG_CLIP_MODE:     clip_mode_q     <= cfg_data_i[0];
      endcase
    end
  end

  logic [DIM_W-1:0] sw, sh;
  assign sw = eff_dim(screen_width_q);
  assign sh = eff_dim(screen_height_q);

  // Frame state.
  logic [HASH_W-1:0] hash_q, hash_d;
  logic [CNT_W-1:0]  count_q;
  logic [POS_W-1:0]  low_x_q, low_y_q, high_x_q, high_y_q;
  logic [POS_W-1:0]  col_q, row_q;
  logic              frame_end_q;
  logic [7:0]        green_q, blue_q;

  // One FNV-1a byte step, shared by the three bytes of a pixel.
  logic [7:0]        fold_byte;
  logic [HASH_W-1:0] hash_mix;

  always_comb begin
    priority if (cmd_i.accept) begin
      fold_byte = in_data_i.red;
    end else if (cmd_i.fold_g) begin
      fold_byte = green_q;
    end else begin
      fold_byte = blue_q;
    end
  end

  assign hash_mix = hash_q ^ {24'd0, fold_byte};
  assign hash_d   = HASH_W'(hash_mix * FNV_PRIME);

  logic             is_match;
  logic             last_col, last_row;
  logic [DIM_W-1:0] col_ext, row_ext;

  assign is_match = (in_data_i == pixel_t'(expected_rgb_q));
  assign col_ext  = {1'b0, col_q};
  assign row_ext  = {1'b0, row_q};
  assign last_col = (col_ext >= sw - DIM_W'(1));
  assign last_row = (row_ext >= sh - DIM_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= FNV_BASIS;
      count_q     <= '0;
      low_x_q     <= POS_LAST;
      low_y_q     <= POS_LAST;
      high_x_q    <= '0;
      high_y_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      frame_end_q <= 1'b0;
    end else if (cmd_i.finish) begin
      hash_q      <= FNV_BASIS;
      count_q     <= '0;
      low_x_q     <= POS_LAST;
      low_y_q     <= POS_LAST;
      high_x_q    <= '0;
      high_y_q    <= '0;
      col_q       <= '0;
      row_q       <= '0;
      frame_end_q <= 1'b0;
    end else if (cmd_i.accept) begin
      hash_q <= hash_d;
      if (is_match) begin
        if (count_q != COUNT_MAX) begin
          count_q <= count_q + CNT_W'(1);
        end
        if (col_q < low_x_q) low_x_q <= col_q;
        if (col_q > high_x_q) high_x_q <= col_q;
        if (row_q < low_y_q) low_y_q <= row_q;
        if (row_q > high_y_q) high_y_q <= row_q;
      end
      frame_end_q <= 1'b0;
      if (!last_col) begin
        col_q <= col_q + POS_W'(1);
      end else if (!last_row) begin
        col_q <= '0;
        row_q <= row_q + POS_W'(1);
      end else begin
        // Position is cleared together with the rest of the frame state.
        frame_end_q <= 1'b1;
      end
    end else if (cmd_i.fold_g || cmd_i.fold_b) begin
      hash_q <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      green_q <= in_data_i.green;
      blue_q  <= in_data_i.blue;
    end
  end

  assign status_o.frame_end = frame_end_q;

  // End-of-frame evaluation.
  logic [DIM_W-1:0]  bw_q, bh_q;
  logic [AREA_W-1:0] area_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.extent) begin
      bw_q <= clip_mode_q ? clip_extent(origin_x_q, rect_width_q, sw) : rect_width_q;
      bh_q <= clip_mode_q ? clip_extent(origin_y_q, rect_height_q, sh) : rect_height_q;
    end
    if (cmd_i.area) begin
      area_q <= bw_q * bh_q;
    end
  end

  logic [DIM_W-1:0]     span_x, span_y;
  logic [VERDICT_W-1:0] verdict;
  logic                 any_match;

  assign any_match = (count_q != '0);
  assign span_x    = {1'b0, high_x_q} - {1'b0, low_x_q} + DIM_W'(1);
  assign span_y    = {1'b0, high_y_q} - {1'b0, low_y_q} + DIM_W'(1);

  always_comb begin
    priority if (!any_match) begin
      verdict = VERDICT_NO_MATCH;
    end else if (clip_mode_q && (low_x_q != origin_x_q || low_y_q != origin_y_q)) begin
      verdict = VERDICT_WRONG_ORIGIN;
    end else if (span_x != bw_q || span_y != bh_q) begin
      verdict = VERDICT_WRONG_SIZE;
    end else if ({1'b0, count_q} != area_q) begin
      verdict = VERDICT_NOT_FILLED;
    end else begin
      verdict = VERDICT_PASS;
    end
  end

  result_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q.verdict       <= verdict;
      out_q.checksum      <= hash_q;
      out_q.matched_count <= count_q;
      out_q.box_left      <= any_match ? low_x_q : '0;
      out_q.box_top       <= any_match ? low_y_q : '0;
      out_q.box_right     <= any_match ? high_x_q : '0;
      out_q.box_bottom    <= any_match ? high_y_q : '0;
      out_q.expect_width  <= bw_q;
      out_q.expect_height <= bh_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

// ===== hdl/color_rect_bbox_checker.sv =====
// Top level of the color rectangle bounding-box checker.
//
// Pixels of a frame arrive in raster order, one transaction each, and every
// pixel is hashed: the FNV-1a hash folds one byte per cycle through a single
// multiply-by-prime unit, and a new pixel is taken once the third byte is
// folded. The last pixel of a frame goes through the expected box size,
// expected area and verdict steps before its result is loaded into the output
// register; loading waits only while the previous result has not yet been
// taken. All other pixels produce no result. The output register lets the next
// frame start while a result is still pending. Configuration must be written
// through a plain write port while no frame pixel is in flight (not enforced).
`default_nettype none

module color_rect_bbox_checker
  import crbc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire pixel_t                in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output result_t                    out_data_o
);

  cmd_t    cmd;
  status_t status;

  crbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  crbc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== hdl/crbc_port_checker.sv =====
// Port-level assertions of the checker and their binding to the top level.
`default_nettype none

module crbc_port_checker
  import crbc_pkg::*;
(
  input wire logic    clk_i,
  input wire logic    rst_ni,
  input wire logic    in_valid_i,
  input wire logic    in_ready_o,
  input wire logic    out_valid_o,
  input wire logic    out_ready_i,
  input wire result_t out_data_o
);

  logic [AREA_W-1:0] exp_area;
  logic [DIM_W-1:0]  span_x;

  assign exp_area = out_data_o.expect_width * out_data_o.expect_height;
  assign span_x   = {1'b0, out_data_o.box_right} - {1'b0, out_data_o.box_left}
                    + DIM_W'(1);

  // A pending result holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // Each pixel occupies the hash unit until its green and blue bytes are folded.
  a_pixel_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("pixel accepted before the previous one was folded");

  a_no_match_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.verdict == VERDICT_NO_MATCH |->
      out_data_o.matched_count == '0 && out_data_o.box_left == '0 &&
      out_data_o.box_top == '0 && out_data_o.box_right == '0 &&
      out_data_o.box_bottom == '0)
    else $error("no-match result carries a box or count");

  a_pass_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.verdict == VERDICT_PASS |->
      {1'b0, out_data_o.matched_count} == exp_area &&
      span_x == out_data_o.expect_width)
    else $error("passing result disagrees with the expected box");

endmodule

bind color_rect_bbox_checker crbc_port_checker u_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
